FILE: rtl/core/sliding_window_range_detector_assert.svh
// Assertion macros shared by the sliding window range detector RTL.
// Expects clk and arst_n in scope at the point of use.
`ifndef SLIDING_WINDOW_RANGE_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_RANGE_DETECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWRD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SWRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/swrd_pkg.sv
// Package for the sliding window range detector: sizes, item and command types,
// controller states and the circular index helper. No dependencies.
`default_nettype none

package swrd_pkg;

	localparam int QUEUE_DEPTH   = 256;
	localparam int COORD_BITS    = 20;
	localparam int WIDTH_BITS    = 21;
	localparam int THR_BITS      = 20;
	localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = (WIDTH_BITS > THR_BITS) ? WIDTH_BITS : THR_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW_WIDTH    = 1'b0,
		CFG_RANGE_THRESHOLD = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		coord_t pos;
		coord_t val;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic pop;
		logic push;
		logic evict;
	} dq_cmd_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic push;
		logic evict;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_any;
		logic evict_any;
	} dp_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_CMP,
		ST_PUSH,
		ST_EVICT_RD,
		ST_EVICT_CMP
	} state_t;

	// (base + off) mod QUEUE_DEPTH, with base < depth and off <= depth
	function automatic idx_t wrap_add(idx_t base, cnt_t off);
		logic [CNT_BITS:0] s;
		s = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(off);
		if (s >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_BITS+1)'(QUEUE_DEPTH);
		end
		return s[IDX_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/swrd_ram.sv
// Generic simple RAM: one write port, two read ports with registered data.
// No dependencies.
`default_nettype none

module swrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
	output logic [WIDTH-1:0]         rd_a_data,
	input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic [WIDTH-1:0]         rd_b_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_data <= mem_q[rd_a_addr];
		rd_b_data <= mem_q[rd_b_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/swrd_deque.sv
// One circular deque of (position, value) entries: head and count pointers
// around a swrd_ram. Depends on swrd_pkg and swrd_ram.
`default_nettype none
`include "sliding_window_range_detector_assert.svh"

module swrd_deque (
	input  logic             clk,
	input  logic             arst_n,
	input  swrd_pkg::dq_cmd_t cmd,
	input  swrd_pkg::entry_t push_entry,
	output swrd_pkg::entry_t back_entry,
	output swrd_pkg::entry_t front_entry,
	output logic             not_empty,
	output logic             full
);

	import swrd_pkg::*;

	idx_t head_q;
	cnt_t count_q;
	idx_t back_idx;
	idx_t wr_idx;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == cnt_t'(QUEUE_DEPTH));
	assign back_idx  = not_empty ? wrap_add(head_q, count_q - cnt_t'(1)) : head_q;
	// full: oldest slot is reused, head moves on
	assign wr_idx    = full ? head_q : wrap_add(head_q, count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.pop) begin
			count_q <= count_q - cnt_t'(1);
		end else if (cmd.push) begin
			if (full) begin
				head_q <= wrap_add(head_q, cnt_t'(1));
			end else begin
				count_q <= count_q + cnt_t'(1);
			end
		end else if (cmd.evict) begin
			head_q  <= wrap_add(head_q, cnt_t'(1));
			count_q <= count_q - cnt_t'(1);
		end
	end

	swrd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (cmd.push),
		.wr_addr  (wr_idx),
		.wr_data  (push_entry),
		.rd_a_addr(back_idx),
		.rd_a_data(back_entry),
		.rd_b_addr(head_q),
		.rd_b_data(front_entry)
	);

	`SWRD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= cnt_t'(QUEUE_DEPTH), "deque count overrun")
	`SWRD_ASSERT_IMPL(a_pop_nonempty, cmd.pop || cmd.evict, not_empty, "removal from empty deque")
	`SWRD_ASSERT_NEXT(a_full_push, cmd.push && full && !cmd.clear, full, "full push lost count")

endmodule

`default_nettype wire

FILE: rtl/core/swrd_datapath.sv
// Datapath: config registers, item latch, min and max deques, compare logic
// and result registers. Depends on swrd_pkg and swrd_deque.
`default_nettype none

module swrd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [swrd_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
	input  logic [swrd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                start_req,
	input  logic [swrd_pkg::COORD_BITS-1:0]     position,
	input  logic [swrd_pkg::COORD_BITS-1:0]     sample,
	input  swrd_pkg::dp_cmd_t                   cmd,
	output swrd_pkg::dp_sts_t                   sts,
	output logic [swrd_pkg::COORD_BITS-1:0]     window_min,
	output logic [swrd_pkg::COORD_BITS-1:0]     window_max,
	output logic                                range_met,
	output logic                                any_met,
	output logic                                overflow
);

	import swrd_pkg::*;

	logic [WIDTH_BITS-1:0] width_q;
	logic [THR_BITS-1:0]   thr_q;
	coord_t                pos_q;
	coord_t                val_q;
	logic                  hit_q;
	logic                  ovf_q;

	coord_t                min_q;
	coord_t                max_q;
	logic                  met_q;
	logic                  any_q;
	logic                  res_ovf_q;

	dq_cmd_t               min_cmd;
	dq_cmd_t               max_cmd;
	entry_t                push_entry;
	entry_t                min_back;
	entry_t                min_front;
	entry_t                max_back;
	entry_t                max_front;
	logic                  min_ne;
	logic                  max_ne;
	logic                  min_full;
	logic                  max_full;

	logic                  min_pop_ok;
	logic                  max_pop_ok;
	logic                  min_evict_ok;
	logic                  max_evict_ok;
	logic [WIDTH_BITS-1:0] width_eff;
	logic [WIDTH_BITS:0]   min_limit;
	logic [WIDTH_BITS:0]   max_limit;
	coord_t                diff;
	logic                  met;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_BITS'(1);
			thr_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_WINDOW_WIDTH:    width_q <= cfg_wdata[WIDTH_BITS-1:0];
				CFG_RANGE_THRESHOLD: thr_q   <= cfg_wdata[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign width_eff = (width_q == '0) ? WIDTH_BITS'(1) : width_q;
	assign push_entry = '{pos: pos_q, val: val_q};

	assign min_pop_ok = min_ne && (min_back.val > val_q);
	assign max_pop_ok = max_ne && (max_back.val < val_q);

	assign min_limit    = (WIDTH_BITS+1)'(min_front.pos) + (WIDTH_BITS+1)'(width_eff);
	assign max_limit    = (WIDTH_BITS+1)'(max_front.pos) + (WIDTH_BITS+1)'(width_eff);
	assign min_evict_ok = min_ne && (min_limit <= (WIDTH_BITS+1)'(pos_q));
	assign max_evict_ok = max_ne && (max_limit <= (WIDTH_BITS+1)'(pos_q));

	assign sts.pop_any   = min_pop_ok || max_pop_ok;
	assign sts.evict_any = min_evict_ok || max_evict_ok;

	always_comb begin
		min_cmd.clear = cmd.load && start_req;
		min_cmd.pop   = cmd.pop && min_pop_ok;
		min_cmd.push  = cmd.push;
		min_cmd.evict = cmd.evict && min_evict_ok;
		max_cmd.clear = cmd.load && start_req;
		max_cmd.pop   = cmd.pop && max_pop_ok;
		max_cmd.push  = cmd.push;
		max_cmd.evict = cmd.evict && max_evict_ok;
	end

	assign diff = max_front.val - min_front.val;
	assign met  = (max_front.val >= min_front.val) && (diff >= thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ovf_q <= 1'b0;
				if (start_req) begin
					hit_q <= 1'b0;
				end
			end
			if (cmd.push) begin
				ovf_q <= min_full || max_full;
			end
			if (cmd.emit) begin
				hit_q <= hit_q || met;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= position;
			val_q <= sample;
		end
		if (cmd.emit) begin
			min_q     <= min_front.val;
			max_q     <= max_front.val;
			met_q     <= met;
			any_q     <= hit_q || met;
			res_ovf_q <= ovf_q;
		end
	end

	assign window_min = min_q;
	assign window_max = max_q;
	assign range_met  = met_q;
	assign any_met    = any_q;
	assign overflow   = res_ovf_q;

	swrd_deque u_min_dq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (min_cmd),
		.push_entry (push_entry),
		.back_entry (min_back),
		.front_entry(min_front),
		.not_empty  (min_ne),
		.full       (min_full)
	);

	swrd_deque u_max_dq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (max_cmd),
		.push_entry (push_entry),
		.back_entry (max_back),
		.front_entry(max_front),
		.not_empty  (max_ne),
		.full       (max_full)
	);

endmodule

`default_nettype wire

FILE: rtl/core/swrd_ctrl.sv
// Controller: sequences pop, push and evict steps for one item at a time and
// owns the result valid flag. Depends on swrd_pkg.
`default_nettype none
`include "sliding_window_range_detector_assert.svh"

module swrd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output swrd_pkg::dp_cmd_t cmd,
	input  swrd_pkg::dp_sts_t sts
);

	import swrd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_POP_RD;
				end
			end
			ST_POP_RD: begin
				state_d = ST_POP_CMP;
			end
			ST_POP_CMP: begin
				cmd.pop = 1'b1;
				state_d = sts.pop_any ? ST_POP_RD : ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_EVICT_RD;
			end
			ST_EVICT_RD: begin
				state_d = ST_EVICT_CMP;
			end
			ST_EVICT_CMP: begin
				cmd.evict = 1'b1;
				if (sts.evict_any) begin
					state_d = ST_EVICT_RD;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	`SWRD_ASSERT_IMPL(a_emit_free, cmd.emit, !result_valid_q || !result_stall, "result overwritten")
	`SWRD_ASSERT_NEXT(a_accept_pop, item_valid && !item_stall, state_q == ST_POP_RD, "accept lost")
	`SWRD_ASSERT_NEXT(a_emit_valid, cmd.emit, result_valid_q && state_q == ST_IDLE, "emit lost")

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_range_detector.sv
// Sliding window range detector top level: swrd_ctrl plus swrd_datapath.
// One item at a time. Each item is loaded, back pops over the two deques loop as RAM
// read then compare, the push follows, front evictions loop the same way, and the
// emit registers result_valid and waits while a held result is stalled.
// Reset clears pointers, sticky flag and control; width resets to 1, threshold to 0.
`default_nettype none

module sliding_window_range_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [swrd_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
	input  logic [swrd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                start_req,
	input  logic [swrd_pkg::COORD_BITS-1:0]     position,
	input  logic [swrd_pkg::COORD_BITS-1:0]     sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [swrd_pkg::COORD_BITS-1:0]     window_min,
	output logic [swrd_pkg::COORD_BITS-1:0]     window_max,
	output logic                                range_met,
	output logic                                any_met,
	output logic                                overflow
);

	import swrd_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	swrd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd         (dp_cmd),
		.sts         (dp_sts)
	);

	swrd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.start_req (start_req),
		.position  (position),
		.sample    (sample),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.window_min(window_min),
		.window_max(window_max),
		.range_met (range_met),
		.any_met   (any_met),
		.overflow  (overflow)
	);

endmodule

`default_nettype wire
